[src/jsu_pkg.sv]
// Package for the JSON string unescaper: phase encoding, result kinds, error causes,
// result and bundle types, and the hex and UTF-8 helper functions.
// No dependencies.
package jsu_pkg;

    // Parser phase within one string token.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEXA,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEXB
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error causes.
    localparam logic [2:0] CAUSE_NO_QUOTE   = 3'd0;
    localparam logic [2:0] CAUSE_CTRL_CHAR  = 3'd1;
    localparam logic [2:0] CAUSE_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] CAUSE_BAD_HEX    = 3'd3;
    localparam logic [2:0] CAUSE_SURROGATE  = 3'd4;
    localparam logic [2:0] CAUSE_EARLY_END  = 3'd5;

    // Upper six bits of high and low surrogates.
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] cause;
    } t_result;

    // All results caused by one input item.
    typedef struct packed {
        t_result [3:0] res;
        logic [2:0]    count;
    } t_bundle;

    // UTF-8 encoding of one code point.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } t_utf8;

    // Hex digit value; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    // Encode a code point (at most 0x10FFFF) into one to four UTF-8 bytes.
    function automatic t_utf8 encode_utf8(input logic [20:0] cp);
        t_utf8 u;
        u.bytes = '0;
        if (cp < 21'h80) begin
            u.bytes[0] = cp[7:0];
            u.count    = 3'd1;
        end else if (cp < 21'h800) begin
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
            u.count    = 3'd2;
        end else if (cp < 21'h10000) begin
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
            u.count    = 3'd3;
        end else begin
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
            u.count    = 3'd4;
        end
        return u;
    endfunction

endpackage

[src/jsu_decode.sv]
// Token parser for the JSON string unescaper: holds the parse state and turns one
// raw byte into a bundle of up to four results. Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_eod,
    input  logic       i_emit,
    output t_bundle    o_bundle
);

    t_phase      r_phase,      n_phase;
    logic [1:0]  r_hex_count,  n_hex_count;
    logic [15:0] r_code_accum, n_code_accum;
    logic [9:0]  r_high_part,  n_high_part;

    logic [4:0]  hexv;
    logic [15:0] acc;
    t_utf8       enc;
    logic [2:0]  nb;
    logic [3:0][7:0] bytes;
    logic        err;
    logic [2:0]  cause;
    logic        closed;
    logic        to_idle;

    // Parse one byte and compute the next state.
    always_comb begin
        n_phase      = r_phase;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        n_high_part  = r_high_part;
        nb           = 3'd0;
        bytes        = '0;
        err          = 1'b0;
        cause        = CAUSE_NO_QUOTE;
        closed       = 1'b0;
        hexv         = hex_value(i_byte);
        acc          = {r_code_accum[11:0], hexv[3:0]};
        enc          = encode_utf8({5'd0, acc});

        case (r_phase)
            PH_BODY: begin
                if (i_byte == 8'h22) begin
                    closed = 1'b1;
                end else if (i_byte < 8'd32) begin
                    err   = 1'b1;
                    cause = CAUSE_CTRL_CHAR;
                end else if (i_byte == 8'h5c) begin
                    n_phase = PH_ESC;
                end else begin
                    bytes[0] = i_byte;
                    nb       = 3'd1;
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                nb      = 3'd1;
                case (i_byte)
                    8'h22, 8'h5c, 8'h2f: bytes[0] = i_byte;
                    8'h62: bytes[0] = 8'd8;
                    8'h66: bytes[0] = 8'd12;
                    8'h6e: bytes[0] = 8'd10;
                    8'h72: bytes[0] = 8'd13;
                    8'h74: bytes[0] = 8'd9;
                    8'h75: begin
                        nb           = 3'd0;
                        n_phase      = PH_HEXA;
                        n_hex_count  = 2'd0;
                        n_code_accum = 16'd0;
                    end
                    default: begin
                        nb    = 3'd0;
                        err   = 1'b1;
                        cause = CAUSE_BAD_ESCAPE;
                    end
                endcase
            end
            PH_HEXA, PH_HEXB: begin
                if (!hexv[4]) begin
                    err   = 1'b1;
                    cause = CAUSE_BAD_HEX;
                end else begin
                    n_code_accum = acc;
                    if (r_hex_count != 2'd3) begin
                        n_hex_count = r_hex_count + 2'd1;
                    end else begin
                        n_hex_count = 2'd0;
                        if (r_phase == PH_HEXA) begin
                            if (acc[15:10] == HIGH_SURR_TAG) begin
                                n_high_part = acc[9:0];
                                n_phase     = PH_WANT_BS;
                            end else if (acc[15:10] == LOW_SURR_TAG) begin
                                err   = 1'b1;
                                cause = CAUSE_SURROGATE;
                            end else begin
                                bytes   = enc.bytes;
                                nb      = enc.count;
                                n_phase = PH_BODY;
                            end
                        end else begin
                            if (acc[15:10] == LOW_SURR_TAG) begin
                                enc = encode_utf8(21'h10000 +
                                                  {1'b0, r_high_part, acc[9:0]});
                                bytes   = enc.bytes;
                                nb      = enc.count;
                                n_phase = PH_BODY;
                            end else begin
                                err   = 1'b1;
                                cause = CAUSE_SURROGATE;
                            end
                        end
                    end
                end
            end
            PH_WANT_BS: begin
                if (i_byte == 8'h5c) begin
                    n_phase = PH_WANT_U;
                end else begin
                    err   = 1'b1;
                    cause = CAUSE_SURROGATE;
                end
            end
            PH_WANT_U: begin
                if (i_byte == 8'h75) begin
                    n_phase      = PH_HEXB;
                    n_hex_count  = 2'd0;
                    n_code_accum = 16'd0;
                end else begin
                    err   = 1'b1;
                    cause = CAUSE_SURROGATE;
                end
            end
            default: begin
                if (i_byte == 8'h22) begin
                    n_phase = PH_BODY;
                end else begin
                    err   = 1'b1;
                    cause = CAUSE_NO_QUOTE;
                end
            end
        endcase

        // End of data without a closing quote is an error of its own.
        if (!err && !closed && i_eod) begin
            err   = 1'b1;
            cause = CAUSE_EARLY_END;
        end

        to_idle = err || closed;
        if (to_idle) begin
            n_phase      = PH_IDLE;
            n_hex_count  = 2'd0;
            n_code_accum = 16'd0;
            n_high_part  = 10'd0;
        end
    end

    // Assemble the result bundle.
    always_comb begin
        o_bundle = '0;
        if (err) begin
            o_bundle.res[0].kind  = KIND_ERROR;
            o_bundle.res[0].cause = cause;
            o_bundle.count        = 3'd1;
        end else if (closed) begin
            // A closing quote never comes with decoded bytes.
            o_bundle.res[0].kind = KIND_CLOSE;
            o_bundle.count       = 3'd1;
        end else if (i_emit) begin
            for (int i = 0; i < 4; i++) begin
                o_bundle.res[i].kind = KIND_BYTE;
                o_bundle.res[i].data = bytes[i];
            end
            o_bundle.count = nb;
        end
    end

    // Parse state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_hex_count  <= 2'd0;
            r_code_accum <= 16'd0;
            r_high_part  <= 10'd0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_hex_count  <= n_hex_count;
            r_code_accum <= n_code_accum;
            r_high_part  <= n_high_part;
        end
    end

endmodule

[src/jsu_serialize.sv]
// Result register for the JSON string unescaper: holds one bundle and sends its
// results one transfer per cycle on the output stream while it is ready. Depends on jsu_pkg.
module jsu_serialize
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_bundle     i_bundle,
    output logic        o_can_load,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte [7:0], error_cause [10:8], zero [15:11]
    output logic [1:0]  m_axis_tuser,   // kind [1:0]
    output logic        m_axis_tlast
);

    logic       r_valid;
    t_bundle    r_bundle;
    logic [1:0] r_idx;
    t_result    cur;
    logic       take;
    logic       is_last;

    assign cur     = r_bundle.res[r_idx];
    assign is_last = ({1'b0, r_idx} == r_bundle.count - 3'd1);
    assign take    = r_valid && m_axis_tready;

    // A new bundle may enter when none is held or as the last result of the held one leaves.
    assign o_can_load = !r_valid || (take && is_last);

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, cur.cause, cur.data};
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = is_last;

    // Bundle payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_bundle <= i_bundle;
        end
    end

    // Valid flag and result index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_can_load) begin
            r_valid <= i_load && (i_bundle.count != 3'd0);
            r_idx   <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

[src/json_string_unescape.sv]
// JSON string unescaper, top level: input register, parser and result register.
// Flow: an accepted byte is held in the input register and parsed when the result register
// can take its bundle; the result register then holds it and offers its first result.
// Throughput: one byte per cycle while no byte yields more than one result and the output
// is ready; else a byte holds the input until its last result is sent, one per transfer.
// Reset (synchronous, active low) returns the parser to idle awaiting the opening quote,
// empties both registers and sets emit_decoded to 1.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,    // emit_decoded
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
    input  logic        s_axis_tlast,   // end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte [7:0], error_cause [10:8], zero [15:11]
    output logic [1:0]  m_axis_tuser,   // kind [1:0]
    output logic        m_axis_tlast    // last
);

    logic       r_emit;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eod;
    logic       can_load;
    logic       dec_fire;
    t_bundle    bundle;

    // The held byte is parsed when the result register can take its bundle.
    assign dec_fire      = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || dec_fire;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b1;
        end else if (i_cfg_we) begin
            r_emit <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eod  <= s_axis_tlast;
        end
    end

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (dec_fire),
        .i_byte   (r_in_byte),
        .i_eod    (r_in_eod),
        .i_emit   (r_emit),
        .o_bundle (bundle)
    );

    jsu_serialize u_serialize (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (dec_fire),
        .i_bundle      (bundle),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
